FILE: sv/pmad_pkg.sv
`default_nettype none

package pmad_pkg;

  localparam int PAGE_ENTRIES = 256;
  localparam int PAGE_BITS = $clog2(PAGE_ENTRIES);
  localparam int HANDLER_SLOTS = 32;
  localparam logic [5:0] HANDLER_LIMIT = 6'(HANDLER_SLOTS);
  localparam int PAGE_SHIFT = 24;

  localparam logic [31:0] FILL_RESET = 32'hDEADC0D3;

  localparam logic [1:0] MODE_ACCESS = 2'd0;
  localparam logic [1:0] MODE_HANDLER = 2'd1;
  localparam logic [1:0] MODE_BLOCK = 2'd2;
  localparam logic [1:0] MODE_MIRROR = 2'd3;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;
  localparam logic [1:0] SIZE_DOUBLE = 2'd3;

  typedef struct packed {
    logic        mem;
    logic [31:0] base;
    logic [4:0]  aux;
  } page_entry_t;

  function automatic logic [63:0] size_mask(input logic [1:0] sz);
    logic [63:0] m;
    case (sz)
      SIZE_BYTE: m = 64'h0000_0000_0000_00FF;
      SIZE_HALF: m = 64'h0000_0000_0000_FFFF;
      SIZE_WORD: m = 64'h0000_0000_FFFF_FFFF;
      default:   m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [5:0] zero_count(input logic [31:0] m);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < 32; i++) begin
      n = n + 6'(!m[i]);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: sv/pmad_table.sv
`default_nettype none

module pmad_table import pmad_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [PAGE_BITS-1:0] rd_addr,
  output page_entry_t               rd_data,
  input  wire logic                 wr_en,
  input  wire logic [PAGE_BITS-1:0] wr_addr,
  input  wire page_entry_t          wr_data
);

  page_entry_t mem [PAGE_ENTRIES];
  page_entry_t mem_q;
  logic [PAGE_ENTRIES-1:0] valid;
  logic valid_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      valid_q <= valid[rd_addr];
    end
  end

  assign rd_data = valid_q ? mem_q : '0;

endmodule

`default_nettype wire

FILE: sv/page_map_address_decoder.sv
`default_nettype none

// Page-mapped address decoder, 256 pages of 16 MiB.
// Raise start with the input word while busy is low; the word is taken at
// that edge. Each result word appears for one cycle with strobe high; the
// receiver cannot stall, so results are never held back.
// An access reads its page entry from a synchronous table with a registered
// read, so its result strobes in the same cycle that busy clears. A
// doubleword handler access adds a second state, and its two word results
// strobe on consecutive cycles (last marks the second).
// A handler or block map checks its request, then writes its pages one at
// a time, since the table has one write port. A mirror copies each entry in
// turn: each copy reads the source, then writes the destination before
// the next read, so overlapping ranges copy in ascending order.
// A rejected map or mirror ends after its check state with error set.
// Map and mirror results carry only last and error.
// Reset clears every entry to handler zero at once through per-entry valid
// bits, sets unmapped_read_value to 0xDEADC0D3 and drops busy and strobe.
// cfg_write_en loads unmapped_read_value; write it only while idle.

module page_map_address_decoder import pmad_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        cfg_write_en,
  input  wire logic [31:0] cfg_write_data,
  input  wire logic [1:0]  mode,
  input  wire logic [31:0] address,
  input  wire logic [1:0]  access_size,
  input  wire logic        is_write,
  input  wire logic [63:0] write_data,
  input  wire logic [7:0]  first_page,
  input  wire logic [7:0]  last_page,
  input  wire logic [4:0]  handler_id,
  input  wire logic [31:0] block_base,
  input  wire logic [31:0] block_mask,
  input  wire logic [7:0]  dest_page,
  input  wire logic [8:0]  page_count,
  output logic             strobe,
  output logic             goes_to_memory,
  output logic [31:0]      target_address,
  output logic [4:0]       target_handler,
  output logic [1:0]       out_size,
  output logic             out_write,
  output logic [63:0]      out_data,
  output logic             last,
  output logic             error
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_SECOND = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_FILL = 3'd4;
  localparam logic [2:0] S_COPY_RD = 3'd5;
  localparam logic [2:0] S_COPY_WR = 3'd6;

  logic [2:0] state;
  logic [31:0] unmapped_read_value;

  logic [1:0]  req_mode;
  logic [31:0] req_address;
  logic [1:0]  req_size;
  logic        req_write;
  logic [63:0] req_data;
  logic [7:0]  req_first;
  logic [7:0]  req_last;
  logic [4:0]  req_handler;
  logic [31:0] req_base;
  logic [31:0] req_mask;
  logic [7:0]  req_dest;
  logic [8:0]  req_count;

  logic [PAGE_BITS-1:0] idx;
  logic [PAGE_BITS-1:0] src;
  logic [PAGE_BITS-1:0] dst;
  logic [8:0] cnt;
  logic [4:0] hold_handler;

  logic accept;
  logic [PAGE_BITS-1:0] rd_addr;
  page_entry_t rd_data;
  logic wr_en;
  logic [PAGE_BITS-1:0] wr_addr;
  page_entry_t wr_data;

  logic mask_ok;
  logic [5:0] zero_bits;
  logic [4:0] block_shift;
  logic bad;
  logic [31:0] offset;
  logic [63:0] fill;

  assign busy = (state != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    case (state)
      S_IDLE:    rd_addr = address[PAGE_SHIFT +: PAGE_BITS];
      S_COPY_RD: rd_addr = src;
      default:   rd_addr = '0;
    endcase
  end

  assign wr_en = (state == S_FILL) || (state == S_COPY_WR);
  assign wr_addr = (state == S_FILL) ? idx : dst;

  always_comb begin
    if (state == S_COPY_WR) begin
      wr_data = rd_data;
    end else if (req_mode == MODE_BLOCK) begin
      wr_data = '{mem: 1'b1, base: req_base, aux: block_shift};
    end else begin
      wr_data = '{mem: 1'b0, base: 32'd0, aux: req_handler};
    end
  end

  pmad_table u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign mask_ok = (req_mask != 32'd0) && ((req_mask & (req_mask + 32'd1)) == 32'd0);
  assign zero_bits = zero_count(req_mask);
  assign block_shift = zero_bits[4:0];

  always_comb begin
    case (req_mode)
      MODE_HANDLER: bad = (req_last < req_first) || ({1'b0, req_handler} >= HANDLER_LIMIT);
      MODE_BLOCK:   bad = (req_last < req_first) || !mask_ok;
      MODE_MIRROR:  bad = (req_count == 9'd0) ||
                          ((req_count == 9'd1) && (req_dest == req_first));
      default:      bad = 1'b0;
    endcase
  end

  assign offset = req_address & (32'hFFFF_FFFF >> rd_data.aux);
  assign fill = (rd_data.aux == 5'd0) ? {32'd0, unmapped_read_value} : 64'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      strobe <= 1'b0;
      unmapped_read_value <= FILL_RESET;
    end else begin
      if (cfg_write_en) begin
        unmapped_read_value <= cfg_write_data;
      end
      case (state)
        S_IDLE: begin
          strobe <= 1'b0;
          if (accept) begin
            state <= (mode == MODE_ACCESS) ? S_LOOK : S_CHECK;
          end
        end
        S_LOOK: begin
          strobe <= 1'b1;
          state <= (!rd_data.mem && req_size == SIZE_DOUBLE) ? S_SECOND : S_IDLE;
        end
        S_SECOND: begin
          strobe <= 1'b1;
          state <= S_IDLE;
        end
        S_CHECK: begin
          strobe <= bad;
          if (bad) begin
            state <= S_IDLE;
          end else if (req_mode == MODE_MIRROR) begin
            state <= S_COPY_RD;
          end else begin
            state <= S_FILL;
          end
        end
        S_FILL: begin
          strobe <= (idx == req_last[PAGE_BITS-1:0]);
          if (idx == req_last[PAGE_BITS-1:0]) begin
            state <= S_IDLE;
          end
        end
        S_COPY_RD: begin
          strobe <= 1'b0;
          state <= S_COPY_WR;
        end
        S_COPY_WR: begin
          strobe <= (cnt == 9'd1);
          if (cnt == 9'd1) begin
            state <= S_IDLE;
          end else begin
            state <= S_COPY_RD;
          end
        end
        default: begin
          strobe <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode <= mode;
      req_address <= address;
      req_size <= access_size;
      req_write <= is_write;
      req_data <= write_data;
      req_first <= first_page;
      req_last <= last_page;
      req_handler <= handler_id;
      req_base <= block_base;
      req_mask <= block_mask;
      req_dest <= dest_page;
      req_count <= page_count;
    end
    case (state)
      S_LOOK: begin
        hold_handler <= rd_data.aux;
        error <= 1'b0;
        out_write <= req_write;
        if (rd_data.mem) begin
          goes_to_memory <= 1'b1;
          target_address <= rd_data.base + offset;
          target_handler <= 5'd0;
          out_size <= req_size;
          out_data <= req_write ? (req_data & size_mask(req_size)) : 64'd0;
          last <= 1'b1;
        end else begin
          goes_to_memory <= 1'b0;
          target_address <= req_address;
          target_handler <= rd_data.aux;
          if (req_size == SIZE_DOUBLE) begin
            last <= 1'b0;
            out_size <= SIZE_WORD;
            out_data <= req_write ? {32'd0, req_data[31:0]} : fill;
          end else begin
            last <= 1'b1;
            out_size <= req_size;
            out_data <= (req_write ? req_data : fill) & size_mask(req_size);
          end
        end
      end
      S_SECOND: begin
        goes_to_memory <= 1'b0;
        target_address <= req_address + 32'd4;
        target_handler <= hold_handler;
        out_size <= SIZE_WORD;
        out_write <= req_write;
        if (req_write) begin
          out_data <= {32'd0, req_data[63:32]};
        end else if (hold_handler == 5'd0) begin
          out_data <= {32'd0, unmapped_read_value};
        end else begin
          out_data <= 64'd0;
        end
        last <= 1'b1;
        error <= 1'b0;
      end
      S_CHECK: begin
        idx <= req_first[PAGE_BITS-1:0];
        src <= req_first[PAGE_BITS-1:0];
        dst <= req_dest[PAGE_BITS-1:0];
        cnt <= req_count;
        goes_to_memory <= 1'b0;
        target_address <= 32'd0;
        target_handler <= 5'd0;
        out_size <= SIZE_BYTE;
        out_write <= 1'b0;
        out_data <= 64'd0;
        last <= 1'b1;
        error <= bad;
      end
      S_FILL: begin
        idx <= idx + 1'b1;
      end
      S_COPY_WR: begin
        src <= src + 1'b1;
        dst <= dst + 1'b1;
        cnt <= cnt - 9'd1;
      end
      default: begin
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) accept |=> busy)
    else $error("busy not raised after accept");

  assert property (@(posedge clk) disable iff (rst) (strobe && !last) |=> (strobe && last))
    else $error("second word of a split access missing");

  assert property (@(posedge clk) disable iff (rst) (strobe && error) |-> last)
    else $error("error reported on a non-final word");

  assert property (@(posedge clk) disable iff (rst) wr_en |-> (state != S_IDLE))
    else $error("table written while idle");

endmodule

`default_nettype wire
